FILE: hw/rtl/hsof_pkg.sv
// shared constants, types and codes for the hot span overlap filter
package hsof_pkg;

  // table depth and derived widths
  localparam int MAX_SPANS = 1024;
  localparam int SPAN_AW   = (MAX_SPANS > 1) ? $clog2(MAX_SPANS) : 1;
  localparam int CNT_W     = $clog2(MAX_SPANS + 1);

  // field widths
  localparam int RANGE_W = 32;
  localparam int IDX_W   = 32;
  localparam int OP_W    = 2;

  // operation codes
  localparam logic [OP_W-1:0] OP_CLEAR  = OP_W'(0);
  localparam logic [OP_W-1:0] OP_APPEND = OP_W'(1);
  localparam logic [OP_W-1:0] OP_QUERY  = OP_W'(2);

  // search sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_SEARCH,
    S_CHECK
  } srch_state_t;

  // commands into the span table
  typedef struct packed {
    logic               clear;
    logic               append;
    logic [RANGE_W-1:0] hot;
  } tbl_cmd_t;

  // table status seen by the search sequencer
  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic             overflow;
  } tbl_stat_t;

  // one span as read back from the table
  typedef struct packed {
    logic [RANGE_W-1:0] span_begin;
    logic [RANGE_W-1:0] span_end;
  } span_t;

endpackage

FILE: hw/rtl/hsof_ram.sv
// generic single write port ram with registered read
module hsof_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                  clk,
  input  logic                  we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]      wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

FILE: hw/rtl/hsof_table.sv
// span table: append and coalesce logic, span count, overflow flag, span memories
module hsof_table import hsof_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  tbl_cmd_t           cmd,
  input  logic [SPAN_AW-1:0] raddr,
  output span_t              rdata,
  output tbl_stat_t          stat
);

  logic [CNT_W-1:0]   count;
  logic               overflow;
  logic [RANGE_W-1:0] last_end;

  logic               reach;
  logic               extend;
  logic               grow;
  logic               open_span;
  logic               drop;
  logic               end_we;
  logic [CNT_W-1:0]   last_idx;
  logic [SPAN_AW-1:0] waddr;

  // coalesce decision against the tail span, compared without wraparound
  always_comb begin
    reach     = {1'b0, cmd.hot} <= ({1'b0, last_end} + (RANGE_W + 1)'(1));
    extend    = cmd.append && (count != '0) && reach;
    grow      = extend && (cmd.hot > last_end);
    open_span = cmd.append && !extend && (count < CNT_W'(MAX_SPANS));
    drop      = cmd.append && !extend && (count >= CNT_W'(MAX_SPANS));
    last_idx  = count - CNT_W'(1);
    end_we    = grow || open_span;
    waddr     = open_span ? count[SPAN_AW-1:0] : last_idx[SPAN_AW-1:0];
  end

  // count and sticky overflow
  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      count    <= '0;
      overflow <= 1'b0;
    end else begin
      if (open_span) begin
        count <= count + CNT_W'(1);
      end
      if (drop) begin
        overflow <= 1'b1;
      end
    end
  end

  // copy of the tail span's end
  always_ff @(posedge clk) begin
    if (end_we) begin
      last_end <= cmd.hot;
    end
  end

  // span begin memory
  hsof_ram #(
    .WIDTH (RANGE_W),
    .DEPTH (MAX_SPANS)
  ) u_begin_ram (
    .clk   (clk),
    .we    (open_span),
    .waddr (waddr),
    .wdata (cmd.hot),
    .raddr (raddr),
    .rdata (rdata.span_begin)
  );

  // span end memory
  hsof_ram #(
    .WIDTH (RANGE_W),
    .DEPTH (MAX_SPANS)
  ) u_end_ram (
    .clk   (clk),
    .we    (end_we),
    .waddr (waddr),
    .wdata (cmd.hot),
    .raddr (raddr),
    .rdata (rdata.span_end)
  );

  assign stat.count    = count;
  assign stat.overflow = overflow;

endmodule

FILE: hw/rtl/hsof_search.sv
// binary search sequencer with one shared compare unit, block counter and result register
module hsof_search import hsof_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               query,
  input  logic               clear,
  input  logic [RANGE_W-1:0] block_first,
  input  logic [RANGE_W-1:0] block_last,
  input  tbl_stat_t          stat,
  input  span_t              rdata,
  output logic [SPAN_AW-1:0] raddr,
  output logic               busy,
  output logic               result_valid,
  output logic [IDX_W-1:0]   block_index,
  output logic               table_overflowed
);

  srch_state_t state, state_next;

  logic [CNT_W-1:0]   lo, lo_next;
  logic [CNT_W-1:0]   hi, hi_next;
  logic [CNT_W-1:0]   mid, mid_next;
  logic [RANGE_W-1:0] first_q;
  logic [RANGE_W-1:0] last_q;
  logic [IDX_W-1:0]   counter;

  logic               go_right;
  logic [CNT_W-1:0]   lo_step;
  logic [CNT_W-1:0]   hi_step;
  logic [CNT_W-1:0]   span_w;
  logic               hit;

  // shared compare unit: one probe of the span end per cycle
  always_comb begin
    go_right = rdata.span_end < first_q;
    lo_step  = go_right ? (mid + CNT_W'(1)) : lo;
    hi_step  = go_right ? hi : mid;
    span_w   = hi_step - lo_step;
    hit      = (lo < stat.count) && (rdata.span_begin <= last_q);
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (query && (stat.count != '0)) begin
          state_next = S_SEARCH;
        end
      end
      S_SEARCH: begin
        if (lo_step >= hi_step) begin
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // search bounds and memory address
  always_comb begin
    lo_next  = lo;
    hi_next  = hi;
    mid_next = mid;
    unique case (state)
      S_IDLE: begin
        lo_next  = '0;
        hi_next  = stat.count;
        mid_next = stat.count >> 1;
      end
      S_SEARCH: begin
        lo_next = lo_step;
        hi_next = hi_step;
        if (lo_step < hi_step) begin
          mid_next = lo_step + (span_w >> 1);
        end else begin
          mid_next = lo_step;
        end
      end
      S_CHECK: begin
        mid_next = mid;
      end
      default: begin
        mid_next = mid;
      end
    endcase
    raddr = mid_next[SPAN_AW-1:0];
  end

  assign busy = (state != S_IDLE);

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // bounds and latched query
  always_ff @(posedge clk) begin
    lo  <= lo_next;
    hi  <= hi_next;
    mid <= mid_next;
    if (query) begin
      first_q <= block_first;
      last_q  <= block_last;
    end
  end

  // block counter: advances once per query, with or without a result
  always_ff @(posedge clk) begin
    if (rst || clear) begin
      counter <= '0;
    end else if ((query && (stat.count == '0)) || (state == S_CHECK)) begin
      counter <= counter + IDX_W'(1);
    end
  end

  // result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= (state == S_CHECK) && hit;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (state == S_CHECK) begin
      block_index      <= counter;
      table_overflowed <= stat.overflow;
    end
  end

endmodule

FILE: hw/rtl/hot_span_overlap_filter.sv
// top level of the hot span overlap filter
// Items are taken when start is high and busy is low. Clear and append finish in the
// cycle they are taken, so busy stays low and the next item may follow at once. A
// query probes the span table (at most 1024 spans) by binary search through one compare
// unit that reads one span per cycle from the span memories; busy stays high until the
// search and its final check are done. A hit is shown on block_index and table_overflowed
// for exactly one cycle with result_valid, in the first cycle after busy falls; the
// receiver cannot stall, so it must take the result in that cycle. Queries with an
// empty table or without overlap give no result but still advance the block counter.
module hot_span_overlap_filter import hsof_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [OP_W-1:0]    operation,
  input  logic [RANGE_W-1:0] hot_range,
  input  logic [RANGE_W-1:0] block_first,
  input  logic [RANGE_W-1:0] block_last,
  output logic               result_valid,
  output logic [IDX_W-1:0]   block_index,
  output logic               table_overflowed
);

  logic               accept;
  logic               query;
  tbl_cmd_t           cmd;
  tbl_stat_t          stat;
  span_t              rdata;
  logic [SPAN_AW-1:0] raddr;

  // operation decode
  always_comb begin
    accept     = start && !busy;
    cmd.clear  = 1'b0;
    cmd.append = 1'b0;
    cmd.hot    = hot_range;
    query      = 1'b0;
    unique case (operation)
      OP_CLEAR:  cmd.clear  = accept;
      OP_APPEND: cmd.append = accept;
      OP_QUERY:  query      = accept;
      default:   query      = 1'b0;
    endcase
  end

  hsof_table u_table (
    .clk   (clk),
    .rst   (rst),
    .cmd   (cmd),
    .raddr (raddr),
    .rdata (rdata),
    .stat  (stat)
  );

  hsof_search u_search (
    .clk              (clk),
    .rst              (rst),
    .query            (query),
    .clear            (cmd.clear),
    .block_first      (block_first),
    .block_last       (block_last),
    .stat             (stat),
    .rdata            (rdata),
    .raddr            (raddr),
    .busy             (busy),
    .result_valid     (result_valid),
    .block_index      (block_index),
    .table_overflowed (table_overflowed)
  );

  // span count never passes the table depth
  assert property (@(posedge clk) disable iff (rst) stat.count <= CNT_W'(MAX_SPANS))
    else $error("span count above table depth");

  // a result only follows a search
  assert property (@(posedge clk) disable iff (rst) result_valid |-> $past(busy))
    else $error("result without a search");

  // a query on a non-empty table holds the block busy
  assert property (@(posedge clk) disable iff (rst)
    (query && (stat.count != '0)) |=> busy)
    else $error("query on filled table did not start a search");

  // reported overflow matches the table's sticky flag
  assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (table_overflowed == stat.overflow))
    else $error("overflow in result differs from table flag");

  // results never come in adjacent cycles
  assert property (@(posedge clk) disable iff (rst) result_valid |=> !result_valid)
    else $error("results in adjacent cycles");

endmodule
